/* src/drb_pkg.sv */
// Shared types, codes and constants for the dead reckoning range and bearing block.
`default_nettype none
package drb_pkg;

   // Mode codes on the request channel.
   localparam logic [1:0] MODE_INIT    = 2'd0;
   localparam logic [1:0] MODE_ADVANCE = 2'd1;
   localparam logic [1:0] MODE_LOAD    = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SHIP_COURSE        = 3'd0;
   localparam logic [2:0] CSR_SHIP_SPEED         = 3'd1;
   localparam logic [2:0] CSR_SHIP_START_RANGE   = 3'd2;
   localparam logic [2:0] CSR_TARGET_COURSE      = 3'd3;
   localparam logic [2:0] CSR_TARGET_SPEED       = 3'd4;
   localparam logic [2:0] CSR_TARGET_START_RANGE = 3'd5;

   localparam int QUEUE_DEPTH = 2;

   // CORDIC datapath widths.
   localparam int XY_W = 36;
   localparam int Z_W  = 34;

   // Inverse CORDIC gain in Q30.
   localparam logic [29:0] KINV_Q30 = 30'd652032874;

   // Tenths of a degree to binary angle: phase = r * PHASE_WHOLE + r * PHASE_EXCESS / 3600.
   localparam logic [20:0] PHASE_WHOLE  = 21'd1193046;
   localparam logic [10:0] PHASE_EXCESS = 11'd1696;
   localparam logic [12:0] RECIP_3600   = 13'd4660;
   localparam logic [11:0] TENTHS_360   = 12'd3600;
   localparam logic [11:0] TENTHS_180   = 12'd1800;
   localparam logic [11:0] TENTHS_90    = 12'd900;

   typedef enum logic [1:0] {
      OP_INIT,
      OP_ADVANCE,
      OP_LOAD
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] load_x;
      logic [31:0] load_y;
   } item_type;

   typedef struct packed {
      logic [11:0] ship_course;
      logic [15:0] ship_speed;
      logic [30:0] ship_start_range;
      logic [11:0] target_course;
      logic [15:0] target_speed;
      logic [30:0] target_start_range;
   } cfg_type;

   typedef struct packed {
      logic                   start;
      logic                   vector;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_cmd_type;

   typedef struct packed {
      logic                   done;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PH_MUL,
      ST_PH_DIV,
      ST_PH_FIX,
      ST_ROT_WAIT,
      ST_JOB_MUL,
      ST_JOB_WR,
      ST_DIFF,
      ST_NORM,
      ST_VEC_WAIT,
      ST_EFIN
   } back_state_type;

   // Arctangent of 2^-i as a 32-bit binary angle (2^32 is a full turn).
   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/drb_front.sv */
// Request intake: accepts transfers, drops unused modes and feeds the command queue.
`default_nettype none
module drb_front import drb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_load_x,
   input  wire logic [31:0] req_load_y,
   input  wire logic        queue_full,
   output logic             push,
   output item_type         push_item
);

   logic     front_valid_ff;
   item_type item_ff;
   logic     accept;
   logic     keep;
   op_type   op;

   assign req_stall = front_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !queue_full;
   assign push_item = item_ff;

   always_comb begin
      keep = 1'b1;
      op   = OP_INIT;
      case (req_mode)
         MODE_INIT:    op = OP_INIT;
         MODE_ADVANCE: op = OP_ADVANCE;
         MODE_LOAD:    op = OP_LOAD;
         default:      keep = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (accept) begin
         front_valid_ff <= keep;
      end else if (push) begin
         front_valid_ff <= 1'b0;
      end
      if (accept) begin
         item_ff.op     <= op;
         item_ff.load_x <= req_load_x;
         item_ff.load_y <= req_load_y;
      end
   end

endmodule
`default_nettype wire

/* src/drb_queue.sv */
// Short command queue between the intake and the execution sequencer.
`default_nettype none
module drb_queue import drb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      head,
   output logic          empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNW = $clog2(QUEUE_DEPTH + 1);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CNW-1:0]   count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* src/drb_cordic.sv */
// Iterative CORDIC unit, one micro-rotation per cycle, in rotation or vectoring mode.
`default_nettype none
module drb_cordic import drb_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cordic_cmd_type cmd,
   output cordic_res_type      res
);

   localparam int IW = $clog2(CORDIC_STEPS);

   logic                   busy_ff;
   logic                   done_ff;
   logic                   vector_ff;
   logic [IW-1:0]          iter_ff;
   logic signed [XY_W-1:0] x_ff;
   logic signed [XY_W-1:0] y_ff;
   logic signed [Z_W-1:0]  z_ff;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [Z_W-1:0]  ang;
   logic                   pos;

   always_comb begin
      dx  = y_ff >>> iter_ff;
      dy  = x_ff >>> iter_ff;
      ang = $signed({2'b00, atan_angle(5'(iter_ff))});
      // Rotation drives z toward zero, vectoring drives y toward zero.
      pos = vector_ff ? !(y_ff > 0) : (z_ff >= 0);
   end

   assign res.done = done_ff;
   assign res.x    = x_ff;
   assign res.y    = y_ff;
   assign res.z    = z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && iter_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (cmd.start) begin
         vector_ff <= cmd.vector;
         iter_ff   <= '0;
         x_ff      <= cmd.x;
         y_ff      <= cmd.y;
         z_ff      <= cmd.z;
      end else if (busy_ff) begin
         iter_ff <= iter_ff + 1'b1;
         if (pos) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - ang;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + ang;
         end
      end
   end

endmodule
`default_nettype wire

/* src/drb_back.sv */
// Execution sequencer: placement, advance, target load and range/bearing output.
`default_nettype none
module drb_back import drb_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 8,
   parameter int CORDIC_STEPS  = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire item_type           head,
   input  wire logic               queue_empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [31:0]             rsp_range_out,
   output logic [11:0]             rsp_bearing_out,
   output logic signed [11:0]      rsp_relative_bearing
);

   localparam int CW  = COORD_WIDTH;
   localparam int SH  = 30 - FRACTION_BITS;
   localparam int AW  = (COORD_WIDTH + 1 > 33) ? COORD_WIDTH + 1 : 33;
   localparam int RSW = $clog2(AW - 31);
   localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (SH - 1);
   localparam logic signed [Z_W-1:0] ANG_90_Z  = 34'sd1073741824;
   localparam logic signed [Z_W-1:0] ANG_180_Z = 34'sd2147483648;

   back_state_type state_ff, state_in;

   logic signed [CW-1:0] ship_e_ff, ship_n_ff, tgt_e_ff, tgt_n_ff;
   logic signed [CW-1:0] ship_ve_ff, ship_vn_ff, tgt_ve_ff, tgt_vn_ff;

   logic [1:0]   angle_ff;
   logic [1:0]   job_ff;
   logic [32:0]  base_ff;
   logic [22:0]  v_ff;
   logic [10:0]  q_est_ff;
   logic         flip_ff;
   logic signed [31:0] cos_ff, sin_ff;
   logic signed [63:0] job_prod_ff;

   logic [AW-1:0]  ae_ff, an_ff;
   logic           de_neg_ff, dn_neg_ff, zero_ff;
   logic [4:0]     lsh_ff;
   logic [RSW-1:0] rsh_ff;
   logic [63:0]    rng_prod_ff;
   logic [42:0]    za_ff;

   logic               rsp_valid_ff;
   logic [31:0]        range_ff;
   logic [11:0]        bearing_ff;
   logic signed [11:0] rel_ff;

   cordic_cmd_type cmd;
   cordic_res_type res;

   drb_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   function automatic logic [11:0] reduce_tenths(input logic [13:0] t);
      logic [13:0] r;
      if (t >= 14'd7200) begin
         r = t - 14'd7200;
      end else if (t >= 14'd3600) begin
         r = t - 14'd3600;
      end else begin
         r = t;
      end
      return r[11:0];
   endfunction

   function automatic logic [CW-1:0] ext_load(input logic [31:0] v);
      logic [CW+31:0] w;
      w = {{CW{v[31]}}, v};
      return w[CW-1:0];
   endfunction

   // Angle for the current placement: ship position, target, ship step.
   logic [11:0] tenths;
   always_comb begin
      case (angle_ff)
         2'd0:    tenths = reduce_tenths(14'd9000 - {2'b00, cfg.ship_course});
         2'd1:    tenths = reduce_tenths({2'b00, cfg.target_course});
         default: tenths = reduce_tenths({2'b00, cfg.ship_course});
      endcase
   end

   // Phase correction and start angle folding.
   logic [34:0]          v_recip;
   logic [23:0]          rem;
   logic [10:0]          q_fix;
   logic [31:0]          phase;
   logic signed [Z_W-1:0] z_raw, z_rot;
   logic                 flip_in;
   always_comb begin
      v_recip = 35'(v_ff) * 35'(RECIP_3600);
      rem     = 24'(v_ff) - 24'(q_est_ff) * 24'(TENTHS_360);
      q_fix   = (rem >= 24'(TENTHS_360)) ? q_est_ff + 1'b1 : q_est_ff;
      phase   = base_ff[31:0] + 32'(q_fix);
      z_raw   = {{2{phase[31]}}, phase};
      flip_in = 1'b0;
      z_rot   = z_raw;
      if (z_raw > ANG_90_Z) begin
         z_rot   = z_raw - ANG_180_Z;
         flip_in = 1'b1;
      end else if (z_raw < -ANG_90_Z) begin
         z_rot   = z_raw + ANG_180_Z;
         flip_in = 1'b1;
      end
   end

   // Placement products.
   logic [30:0]        mag;
   logic signed [31:0] mag_s, trig;
   logic signed [63:0] prod_job;
   logic signed [63:0] rounded;
   logic [CW-1:0]      coord;
   logic               last_job;
   always_comb begin
      if (!job_ff[1]) begin
         mag = (angle_ff == 2'd0) ? cfg.ship_start_range : cfg.target_start_range;
      end else begin
         mag = (angle_ff == 2'd2) ? {15'd0, cfg.ship_speed} : {15'd0, cfg.target_speed};
      end
      mag_s    = $signed({1'b0, mag});
      trig     = job_ff[0] ? cos_ff : sin_ff;
      prod_job = mag_s * trig;
      rounded  = (job_prod_ff + HALF_LSB) >>> SH;
      coord    = rounded[CW-1:0];
      last_job = (angle_ff == 2'd0) ? (job_ff == 2'd1) : (job_ff == 2'd3);
   end

   // Difference and normalization.
   logic signed [CW:0] de, dn;
   logic [CW:0]        ade, adn;
   logic [AW-1:0]      m;
   logic               m_zero, m_big, m_small;
   always_comb begin
      de      = {tgt_e_ff[CW-1], tgt_e_ff} - {ship_e_ff[CW-1], ship_e_ff};
      dn      = {tgt_n_ff[CW-1], tgt_n_ff} - {ship_n_ff[CW-1], ship_n_ff};
      ade     = de[CW] ? -de : de;
      adn     = dn[CW] ? -dn : dn;
      m       = (ae_ff > an_ff) ? ae_ff : an_ff;
      m_zero  = (m == '0);
      m_big   = (m[AW-1:32] != '0);
      m_small = !m_big && !m[31];
   end

   // Vectoring result scaling.
   logic [34:0] x_clamp;
   logic [30:0] z_clamp;
   always_comb begin
      x_clamp = (res.x < 0) ? 35'd0 : res.x[34:0];
      if (res.z < 0) begin
         z_clamp = 31'd0;
      end else if (res.z > ANG_90_Z) begin
         z_clamp = 31'h40000000;
      end else begin
         z_clamp = res.z[30:0];
      end
   end

   // Final range, bearing and relative bearing.
   logic [64:0]        sum_r, sum_l, shr_l;
   logic [34:0]        v_r;
   logic [31:0]        limit;
   logic [31:0]        range_val;
   logic [43:0]        za_sum;
   logic [10:0]        a;
   logic [11:0]        quad, bearing_val;
   logic signed [12:0] rel_raw, rel_val;
   always_comb begin
      sum_r = {1'b0, rng_prod_ff} + 65'h20000000;
      v_r   = sum_r[64:30];
      limit = 32'hFFFFFFFF >> rsh_ff;
      sum_l = {1'b0, rng_prod_ff} + (65'd1 << (6'd29 + {1'b0, lsh_ff}));
      shr_l = sum_l >> (6'd30 + {1'b0, lsh_ff});
      if (zero_ff) begin
         range_val = 32'd0;
      end else if (rsh_ff != '0) begin
         range_val = (v_r > {3'b000, limit}) ? 32'hFFFFFFFF : (v_r[31:0] << rsh_ff);
      end else begin
         range_val = (shr_l[64:32] != '0) ? 32'hFFFFFFFF : shr_l[31:0];
      end
      za_sum = {1'b0, za_ff} + 44'h80000000;
      a      = za_sum[42:32];
      if (!de_neg_ff) begin
         quad = dn_neg_ff ? TENTHS_180 - 12'(a) : 12'(a);
      end else begin
         quad = dn_neg_ff ? TENTHS_180 + 12'(a) : TENTHS_360 - 12'(a);
      end
      if (zero_ff || quad == TENTHS_360) begin
         bearing_val = 12'd0;
      end else begin
         bearing_val = quad;
      end
      rel_raw = $signed({1'b0, bearing_val}) - $signed({1'b0, cfg.ship_course});
      if (rel_raw > $signed({1'b0, TENTHS_180})) begin
         rel_val = rel_raw - $signed({1'b0, TENTHS_360});
      end else if (rel_raw <= -$signed({1'b0, TENTHS_180})) begin
         rel_val = rel_raw + $signed({1'b0, TENTHS_360});
      end else begin
         rel_val = rel_raw;
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state, queue pop and CORDIC commands.
   always_comb begin
      state_in   = state_ff;
      pop        = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               case (head.op)
                  OP_INIT:    state_in = ST_PH_MUL;
                  OP_ADVANCE: state_in = ST_DIFF;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_PH_MUL: state_in = ST_PH_DIV;
         ST_PH_DIV: state_in = ST_PH_FIX;
         ST_PH_FIX: begin
            cmd.start  = 1'b1;
            cmd.vector = 1'b0;
            cmd.x      = $signed({6'd0, KINV_Q30});
            cmd.y      = '0;
            cmd.z      = z_rot;
            state_in   = ST_ROT_WAIT;
         end
         ST_ROT_WAIT: begin
            if (res.done) begin
               state_in = ST_JOB_MUL;
            end
         end
         ST_JOB_MUL: state_in = ST_JOB_WR;
         ST_JOB_WR: begin
            if (!last_job) begin
               state_in = ST_JOB_MUL;
            end else if (angle_ff == 2'd2) begin
               state_in = ST_DIFF;
            end else begin
               state_in = ST_PH_MUL;
            end
         end
         ST_DIFF: state_in = ST_NORM;
         ST_NORM: begin
            if (m_zero) begin
               state_in = ST_EFIN;
            end else if (!m_big && !m_small) begin
               cmd.start  = 1'b1;
               cmd.vector = 1'b1;
               cmd.x      = $signed({3'd0, an_ff[32:0]});
               cmd.y      = $signed({3'd0, ae_ff[32:0]});
               cmd.z      = '0;
               state_in   = ST_VEC_WAIT;
            end
         end
         ST_VEC_WAIT: begin
            if (res.done) begin
               state_in = ST_EFIN;
            end
         end
         ST_EFIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ship_e_ff    <= '0;
         ship_n_ff    <= '0;
         tgt_e_ff     <= '0;
         tgt_n_ff     <= '0;
         ship_ve_ff   <= '0;
         ship_vn_ff   <= '0;
         tgt_ve_ff    <= '0;
         tgt_vn_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EFIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  case (head.op)
                     OP_INIT: begin
                        angle_ff <= 2'd0;
                        job_ff   <= 2'd0;
                     end
                     OP_ADVANCE: begin
                        ship_e_ff <= ship_e_ff + ship_ve_ff;
                        ship_n_ff <= ship_n_ff + ship_vn_ff;
                        tgt_e_ff  <= tgt_e_ff + tgt_ve_ff;
                        tgt_n_ff  <= tgt_n_ff + tgt_vn_ff;
                     end
                     default: begin
                        tgt_e_ff <= ext_load(head.load_x);
                        tgt_n_ff <= ext_load(head.load_y);
                     end
                  endcase
               end
            end
            ST_PH_MUL: begin
               base_ff <= 33'(tenths) * 33'(PHASE_WHOLE);
               v_ff    <= 23'(tenths) * 23'(PHASE_EXCESS) + 23'(TENTHS_180);
            end
            ST_PH_DIV: begin
               q_est_ff <= v_recip[34:24];
            end
            ST_PH_FIX: begin
               flip_ff <= flip_in;
            end
            ST_ROT_WAIT: begin
               if (res.done) begin
                  cos_ff <= flip_ff ? 32'(-res.x) : res.x[31:0];
                  sin_ff <= flip_ff ? 32'(-res.y) : res.y[31:0];
               end
            end
            ST_JOB_MUL: begin
               job_prod_ff <= prod_job;
            end
            ST_JOB_WR: begin
               case (job_ff)
                  2'd0: begin
                     if (angle_ff == 2'd0) ship_e_ff <= coord;
                     else                  tgt_e_ff  <= coord;
                  end
                  2'd1: begin
                     if (angle_ff == 2'd0) ship_n_ff <= coord;
                     else                  tgt_n_ff  <= coord;
                  end
                  2'd2: begin
                     if (angle_ff == 2'd2) ship_ve_ff <= coord;
                     else                  tgt_ve_ff  <= coord;
                  end
                  default: begin
                     if (angle_ff == 2'd2) ship_vn_ff <= coord;
                     else                  tgt_vn_ff  <= coord;
                  end
               endcase
               if (last_job) begin
                  angle_ff <= angle_ff + 1'b1;
                  job_ff   <= (angle_ff == 2'd1) ? 2'd2 : 2'd0;
               end else begin
                  job_ff <= job_ff + 1'b1;
               end
            end
            ST_DIFF: begin
               ae_ff     <= AW'(ade);
               an_ff     <= AW'(adn);
               de_neg_ff <= de[CW];
               dn_neg_ff <= dn[CW];
               lsh_ff    <= '0;
               rsh_ff    <= '0;
            end
            ST_NORM: begin
               zero_ff <= m_zero;
               if (!m_zero && m_big) begin
                  ae_ff  <= ae_ff >> 1;
                  an_ff  <= an_ff >> 1;
                  rsh_ff <= rsh_ff + 1'b1;
               end else if (!m_zero && m_small) begin
                  ae_ff  <= ae_ff << 1;
                  an_ff  <= an_ff << 1;
                  lsh_ff <= lsh_ff + 1'b1;
               end
            end
            ST_VEC_WAIT: begin
               if (res.done) begin
                  rng_prod_ff <= 64'(x_clamp) * 64'(KINV_Q30);
                  za_ff       <= 43'(z_clamp) * 43'(TENTHS_360);
               end
            end
            ST_EFIN: begin
               if (out_free) begin
                  range_ff     <= range_val;
                  bearing_ff   <= bearing_val;
                  rel_ff       <= rel_val[11:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_range_out        = range_ff;
   assign rsp_bearing_out      = bearing_ff;
   assign rsp_relative_bearing = rel_ff;

endmodule
`default_nettype wire

/* src/dead_reckon_range_bearing.sv */
// Top level of the dead reckoning range and bearing block.
`default_nettype none
// Dead reckoning range and bearing. A request transfer carries a mode: initialise (0) places
// the own ship and the target from the configuration registers, stores both per-tick step
// vectors and returns one result; advance (1) moves both positions by one step and returns one
// result; load (2) sets the target position from load_x/load_y and returns nothing; mode 3 is
// taken and ignored. A result holds the saturating range in Q.FRACTION_BITS, the compass
// bearing from ship to target and that bearing relative to the ship course, both in tenths of
// a degree. Work goes through a single iterative CORDIC unit that does one micro-rotation a
// cycle. An advance shifts the larger coordinate difference one bit at a time into the range
// 2^31..2^32 for the vectoring pass. An initialise first runs three placement passes, each a
// rotation followed by its products. A load is done as the command leaves the queue. A short
// command queue sits between intake and execution, so new requests are taken while a result
// still waits on the response side. Configuration is written through csr_wr_en, csr_index and
// csr_wdata and must only change while no request is in flight.
module dead_reckon_range_bearing import drb_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 8,
   parameter int CORDIC_STEPS  = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [30:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [31:0] req_load_x,
   input  wire logic signed [31:0] req_load_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [31:0]             rsp_range_out,
   output logic [11:0]             rsp_bearing_out,
   output logic signed [11:0]      rsp_relative_bearing
);

   cfg_type  cfg_ff;
   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     queue_empty;
   logic     pop;
   item_type head;

   // Configuration registers; writes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SHIP_COURSE:        cfg_ff.ship_course        <= csr_wdata[11:0];
            CSR_SHIP_SPEED:         cfg_ff.ship_speed         <= csr_wdata[15:0];
            CSR_SHIP_START_RANGE:   cfg_ff.ship_start_range   <= csr_wdata;
            CSR_TARGET_COURSE:      cfg_ff.target_course      <= csr_wdata[11:0];
            CSR_TARGET_SPEED:       cfg_ff.target_speed       <= csr_wdata[15:0];
            CSR_TARGET_START_RANGE: cfg_ff.target_start_range <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The intake holds one transfer and forwards it into the queue.
   drb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_load_x (req_load_x),
      .req_load_y (req_load_y),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   drb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   // The sequencer executes one command at a time and owns the output register.
   drb_back #(
      .COORD_WIDTH   (COORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS),
      .CORDIC_STEPS  (CORDIC_STEPS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head                 (head),
      .queue_empty          (queue_empty),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_range_out        (rsp_range_out),
      .rsp_bearing_out      (rsp_bearing_out),
      .rsp_relative_bearing (rsp_relative_bearing)
   );

endmodule
`default_nettype wire
